// ===== rtl/core/bfdh_pkg.sv =====
// ----------------------------------------------------------------------------
// bfdh_pkg
// Shared widths, register indexes and codes for the double-hash Bloom filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bfdh_pkg;

    // field widths
    localparam int HASH_W       = 64;
    localparam int NUM_BITS_W   = 17;
    localparam int NUM_HASHES_W = 6;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 32;

    // store word layout: 32 filter bits per memory word
    localparam int WORD_W  = 32;
    localparam int WORD_SH = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BITS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES = 8'd1;

    // register reset values and probe count limits
    localparam logic [NUM_BITS_W-1:0]   NUM_BITS_RST   = 17'd65536;
    localparam logic [NUM_HASHES_W-1:0] NUM_HASHES_RST = 6'd8;
    localparam logic [NUM_HASHES_W-1:0] HASHES_MIN     = 6'd2;
    localparam logic [NUM_HASHES_W-1:0] HASHES_MAX     = 6'd32;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TEST   = 1'b1;

    typedef logic [HASH_W-1:0] t_hash;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

endpackage

`default_nettype wire

// ===== rtl/core/bfdh_ram.sv =====
// ----------------------------------------------------------------------------
// bfdh_ram
// Generic single-port RAM, read-first, with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bfdh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write on request, read the old contents every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/bloom_filter_double_hash_core.sv =====
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_core
// Bloom filter with double hashing over a word-organized bit store.
// Operation: each item first reduces the two hashes and 2^64 modulo the bit
//   count, one bit per cycle, and each probe then passes through a read state
//   and a check/write state of the store.
// Flow: a new item is taken only while busy is low, once the last one is done;
//   a test stops early at the first clear bit. The result strobe lasts one cycle, no stall.
// Reset: the store is swept clear, one 32-bit word per cycle, across all
//   ceil(MAX_BITS/32) words after reset (2048 by default) with busy high.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_double_hash_core #(
    parameter int MAX_BITS = 65536
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // item command
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_operation,
    input  wire bfdh_pkg::t_hash       i_hash_a,
    input  wire bfdh_pkg::t_hash       i_hash_b,
    // result
    output logic                       o_valid,
    output logic                       o_present,
    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire bfdh_pkg::t_cfg_idx    i_cfg_index,
    input  wire bfdh_pkg::t_cfg_data   i_cfg_data
);

    import bfdh_pkg::*;

    localparam int MW    = $clog2(MAX_BITS + 1);
    localparam int DEPTH = (MAX_BITS + WORD_W - 1) / WORD_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(HASH_W);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;

    // control state
    logic [2:0]              r_state;
    logic [AW-1:0]           r_clr;
    logic [CW-1:0]           r_cnt;
    logic [NUM_HASHES_W-1:0] r_probe;
    logic                    r_valid;
    logic [NUM_BITS_W-1:0]   r_num_bits;
    logic [NUM_HASHES_W-1:0] r_num_hashes;

    // item payload
    logic                    r_op;
    logic [MW-1:0]           r_m;
    logic [NUM_HASHES_W-1:0] r_k;
    t_hash                   r_h;
    t_hash                   r_stride;
    t_hash                   r_sa;
    t_hash                   r_sb;
    logic [MW-1:0]           r_ra;
    logic [MW-1:0]           r_rb;
    logic [MW-1:0]           r_rc;
    logic [MW-1:0]           r_res;
    logic [MW-1:0]           r_bm;
    logic [MW-1:0]           r_c;
    logic [AW-1:0]           r_addr;
    logic [WORD_SH-1:0]      r_bit;
    logic                    r_present;

    // next values
    logic [MW-1:0]           n_ra;
    logic [MW-1:0]           n_rb;
    logic [MW-1:0]           n_rc;
    logic [MW-1:0]           n_c;
    logic [MW-1:0]           n_res;
    logic [MW-1:0]           m_eff;
    logic [NUM_HASHES_W-1:0] k_eff;
    logic [HASH_W:0]         h_sum;
    logic [MW:0]             c_inc;
    logic signed [MW+1:0]    t_acc;

    // store port
    logic                    mem_we;
    logic [AW-1:0]           mem_addr;
    logic [WORD_W-1:0]       mem_wdata;
    logic [WORD_W-1:0]       mem_rdata;
    logic                    probe_bit;
    logic                    probe_last;
    logic                    accept;

    // one restoring remainder step: shift in a dividend bit, subtract if it fits
    function automatic logic [MW-1:0] rem_step(input logic [MW-1:0] rem,
                                               input logic din,
                                               input logic [MW-1:0] m);
        logic [MW:0] wide;
        wide = {rem, din};
        if (wide >= {1'b0, m}) begin
            wide = wide - {1'b0, m};
        end
        return wide[MW-1:0];
    endfunction

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_present   = r_present;
    assign o_cfg_ready = 1'b1;

    // clamp the configured bit count and probe count
    always_comb begin
        if (r_num_bits == '0) begin
            m_eff = MW'(1);
        end else if (32'(r_num_bits) > 32'(MAX_BITS)) begin
            m_eff = MW'(MAX_BITS);
        end else begin
            m_eff = MW'(r_num_bits);
        end
        if (r_num_hashes < HASHES_MIN) begin
            k_eff = HASHES_MIN;
        end else if (r_num_hashes > HASHES_MAX) begin
            k_eff = HASHES_MAX;
        end else begin
            k_eff = r_num_hashes;
        end
    end

    // remainder lanes: hash_a, hash_b and 2^64 - 1
    always_comb begin
        n_ra  = rem_step(r_ra, r_sa[HASH_W-1], r_m);
        n_rb  = rem_step(r_rb, r_sb[HASH_W-1], r_m);
        n_rc  = rem_step(r_rc, 1'b1, r_m);
        c_inc = {1'b0, n_rc} + (MW+1)'(1);
        n_c   = (c_inc == {1'b0, r_m}) ? '0 : c_inc[MW-1:0];
    end

    // advance the residue: add the stride residue, take back 2^64 mod m on wrap
    always_comb begin
        h_sum = {1'b0, r_h} + {1'b0, r_stride};
        t_acc = $signed({2'b00, r_res}) + $signed({2'b00, r_bm});
        if (h_sum[HASH_W]) begin
            t_acc = t_acc - $signed({2'b00, r_c});
        end
        if (t_acc[MW+1]) begin
            t_acc = t_acc + $signed({2'b00, r_m});
        end else if (t_acc >= $signed({2'b00, r_m})) begin
            t_acc = t_acc - $signed({2'b00, r_m});
        end
        n_res = t_acc[MW-1:0];
    end

    assign probe_bit  = mem_rdata[r_bit];
    assign probe_last = (r_probe == (r_k - NUM_HASHES_W'(1)));

    // store port mux: sweep during clear, read a probe, write it back on insert
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_addr;
        mem_wdata = mem_rdata | (WORD_W'(1) << r_bit);
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = '0;
            end
            ST_READ: begin
                mem_addr = AW'(r_res >> WORD_SH);
            end
            ST_CHECK: begin
                mem_we = (r_op == OP_INSERT);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    bfdh_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // control sequencer and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_cnt        <= '0;
            r_probe      <= '0;
            r_valid      <= 1'b0;
            r_num_bits   <= NUM_BITS_RST;
            r_num_hashes <= NUM_HASHES_RST;
        end else begin
            // strobe a test result on its first clear bit or after its last probe
            r_valid <= (r_state == ST_CHECK) && (r_op == OP_TEST)
                       && (!probe_bit || probe_last);
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_NUM_BITS) begin
                    r_num_bits <= i_cfg_data[NUM_BITS_W-1:0];
                end else if (i_cfg_index == CFG_NUM_HASHES) begin
                    r_num_hashes <= i_cfg_data[NUM_HASHES_W-1:0];
                end
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_cnt   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(HASH_W - 1)) begin
                        r_probe <= '0;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_probe <= r_probe + NUM_HASHES_W'(1);
                    if ((r_op == OP_TEST && !probe_bit) || probe_last) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_READ;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // item datapath: capture, reduce, step through the probes
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_op     <= i_operation;
                    r_m      <= m_eff;
                    r_k      <= k_eff;
                    r_h      <= i_hash_a;
                    r_stride <= i_hash_b;
                    r_sa     <= i_hash_a;
                    r_sb     <= i_hash_b;
                    r_ra     <= '0;
                    r_rb     <= '0;
                    r_rc     <= '0;
                end
            end
            ST_DIV: begin
                r_sa <= r_sa << 1;
                r_sb <= r_sb << 1;
                r_ra <= n_ra;
                r_rb <= n_rb;
                r_rc <= n_rc;
                if (r_cnt == CW'(HASH_W - 1)) begin
                    r_res <= n_ra;
                    r_bm  <= n_rb;
                    r_c   <= n_c;
                end
            end
            ST_READ: begin
                r_addr <= AW'(r_res >> WORD_SH);
                r_bit  <= r_res[WORD_SH-1:0];
                r_res  <= n_res;
                r_h    <= h_sum[HASH_W-1:0];
            end
            ST_CHECK: begin
                if (r_op == OP_TEST && !probe_bit) begin
                    r_present <= 1'b0;
                end else if (probe_last) begin
                    r_present <= 1'b1;
                end
            end
            default: begin
                r_present <= r_present;
            end
        endcase
    end

    // a result only ever follows a probe check
    a_valid_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == ST_CHECK)
        else $error("result strobe without a probe check");

    // the running residue stays below the bit count while probing
    a_res_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ || r_state == ST_CHECK) |-> r_res < r_m)
        else $error("probe residue out of range");

    // the probe counter never runs past the probe count
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ || r_state == ST_CHECK) |-> r_probe < r_k)
        else $error("probe counter overrun");

    // an accepted item starts the reduction
    a_accept_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_DIV)
        else $error("accepted item did not start reduction");

endmodule

`default_nettype wire

// ===== sim/tb_bloom_filter_double_hash_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bloom_filter_double_hash_core
// Self-checking bench for the double-hash Bloom filter core. A clocked driver
// feeds insert and test items from a queue and keeps a shadow copy of the
// filter store and registers. A clocked monitor checks every presence result
// against the oldest predicted one. Directed items cover the hash extremes and
// register corner cases; random phases switch settings and mix inserts,
// re-tests of inserted keys and tests of fresh keys.
// ----------------------------------------------------------------------------

module tb_bloom_filter_double_hash_core;

    import bfdh_pkg::*;

    localparam int FILTER_BITS   = 65536;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_CYCLES = 65 + 2 * 32 + 16;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int KEY_POOL_MAX  = 64;

    // index that no register answers to
    localparam t_cfg_idx CFG_UNUSED = 8'hA5;

    localparam t_hash HASH_ZERO = '0;
    localparam t_hash HASH_ONES = '1;

    typedef struct packed {
        logic  op;
        t_hash hash_a;
        t_hash hash_b;
    } t_key_cmd;

    typedef struct packed {
        t_hash hash_a;
        t_hash hash_b;
    } t_key;

    // DUT ports
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      start       = 1'b0;
    logic      busy;
    logic      i_operation = OP_INSERT;
    t_hash     i_hash_a    = '0;
    t_hash     i_hash_b    = '0;
    logic      o_valid;
    logic      o_present;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    t_cfg_idx  i_cfg_index = CFG_NUM_BITS;
    t_cfg_data i_cfg_data  = '0;

    // shadow state of the filter; bit type starts cleared like the swept store
    bit                      shadow_bits [FILTER_BITS];
    logic [NUM_BITS_W-1:0]   shadow_num_bits;
    logic [NUM_HASHES_W-1:0] shadow_num_hashes;

    t_key_cmd    key_cmd_q[$];
    logic        expected_present_q[$];
    t_key        key_pool[$];

    int unsigned idle_left    = 0;
    bit          idle_on_free = 1'b0;
    bit          no_idle      = 1'b0;
    int          fail_count   = 0;
    int unsigned cycle_count  = 0;
    int          random_count;

    bloom_filter_double_hash_core #(
        .MAX_BITS (FILTER_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_hash_a    (i_hash_a),
        .i_hash_b    (i_hash_b),
        .o_valid     (o_valid),
        .o_present   (o_present),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Walk the probe sequence of one item over the shadow store: set bits on
    // insert, predict presence on test.
    task automatic filter_probe(input logic op, input t_hash ha, input t_hash hb);
        logic [63:0] span;
        logic [63:0] pos;
        t_hash       probe;
        int unsigned probes;
        logic        hit;
        // clamp the bit count: zero acts as one, oversize saturates
        if (shadow_num_bits == '0) begin
            span = 64'd1;
        end else if (shadow_num_bits > FILTER_BITS) begin
            span = 64'(FILTER_BITS);
        end else begin
            span = 64'(shadow_num_bits);
        end
        // clamp the probe count to 2..32
        if (shadow_num_hashes < HASHES_MIN) begin
            probes = int'(HASHES_MIN);
        end else if (shadow_num_hashes > HASHES_MAX) begin
            probes = int'(HASHES_MAX);
        end else begin
            probes = int'(shadow_num_hashes);
        end
        probe = ha;
        hit   = 1'b1;
        for (int i = 0; i < probes; i++) begin
            pos = probe % span;
            if (op == OP_INSERT) begin
                shadow_bits[pos[15:0]] = 1'b1;
            end else if (!shadow_bits[pos[15:0]]) begin
                hit = 1'b0;
            end
            probe = probe + hb;
        end
        if (op == OP_TEST) begin
            expected_present_q.push_back(hit);
        end
    endtask

    // Put the next pending item on the command ports.
    task automatic present_next();
        t_key_cmd cmd;
        cmd = key_cmd_q.pop_front();
        i_operation <= cmd.op;
        i_hash_a    <= cmd.hash_a;
        i_hash_b    <= cmd.hash_b;
    endtask

    // Item driver: predict on acceptance, then idle or present the next item.
    always @(posedge i_clk) begin : item_driver
        logic next_start;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_operation <= OP_INSERT;
            i_hash_a    <= '0;
            i_hash_b    <= '0;
            idle_left    = 0;
        end else begin
            next_start = start;
            if (start && !busy) begin
                filter_probe(i_operation, i_hash_a, i_hash_b);
                // draw the wait before the next item; flip into or out of bursts
                if ($urandom_range(0, 15) == 0) begin
                    no_idle = !no_idle;
                end
                idle_left    = no_idle ? 0 : $urandom_range(0, 3);
                idle_on_free = $urandom_range(0, 1);
                if (idle_left == 0 && key_cmd_q.size() != 0) begin
                    present_next();
                    next_start = 1'b1;
                end else begin
                    next_start = 1'b0;
                end
            end else if (!start) begin
                if (idle_left != 0) begin
                    // count down either every cycle or only while the block is free
                    if (!idle_on_free || !busy) begin
                        idle_left--;
                    end
                end else if (key_cmd_q.size() != 0) begin
                    present_next();
                    next_start = 1'b1;
                end
            end
            start <= next_start;
        end
    end

    // Result monitor: compare each strobed result with the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        logic want;
        if (i_rst_n && o_valid) begin
            if (expected_present_q.size() == 0) begin
                $error("present: expected none, actual %0b", o_present);
                fail_count++;
            end else begin
                want = expected_present_q.pop_front();
                if (o_present !== want) begin
                    $error("present: expected %0b, actual %0b", want, o_present);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_hash rand_hash();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_item(input logic op, input t_hash ha, input t_hash hb);
        t_key_cmd cmd;
        cmd.op     = op;
        cmd.hash_a = ha;
        cmd.hash_b = hb;
        key_cmd_q.push_back(cmd);
    endtask

    // Write one register and mirror it in the shadow copy on the handshake.
    task automatic set_reg(input t_cfg_idx idx, input t_cfg_data data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_NUM_BITS) begin
            shadow_num_bits = data[NUM_BITS_W-1:0];
        end else if (idx == CFG_NUM_HASHES) begin
            shadow_num_hashes = data[NUM_HASHES_W-1:0];
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every item is taken and answered, then let the last insert finish.
    task automatic settle_block();
        @(negedge i_clk);
        while (key_cmd_q.size() != 0 || start) @(negedge i_clk);
        while (expected_present_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Pick a random setting for both registers, extremes included.
    task automatic pick_setting();
        t_cfg_data bits_data;
        t_cfg_data hashes_data;
        case ($urandom_range(0, 5))
            0: bits_data = $urandom_range(1, 64);
            1: bits_data = $urandom_range(1, FILTER_BITS);
            2: bits_data = FILTER_BITS;
            3: bits_data = 1;
            4: bits_data = $urandom_range(0, 32'h1FFFF);
            default: bits_data = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0: hashes_data = t_cfg_data'(HASHES_MIN);
            1: hashes_data = t_cfg_data'(HASHES_MAX);
            2: hashes_data = $urandom;
            default: hashes_data = $urandom_range(0, 63);
        endcase
        if ($urandom_range(0, 3) == 0) begin
            set_reg(CFG_UNUSED, $urandom);
        end
        if ($urandom_range(0, 1) == 0) begin
            set_reg(CFG_NUM_BITS, bits_data);
            set_reg(CFG_NUM_HASHES, hashes_data);
        end else begin
            set_reg(CFG_NUM_HASHES, hashes_data);
            set_reg(CFG_NUM_BITS, bits_data);
        end
    endtask

    // Build one random item: inserts of fresh keys, re-tests of known keys,
    // and tests of keys never inserted.
    task automatic random_item();
        int unsigned roll;
        t_key        key;
        roll = $urandom_range(0, 99);
        key.hash_a = rand_hash();
        key.hash_b = ($urandom_range(0, 7) == 0) ? t_hash'($urandom_range(0, 3)) : rand_hash();
        if (roll < 40) begin
            queue_item(OP_INSERT, key.hash_a, key.hash_b);
            key_pool.push_back(key);
            if (key_pool.size() > KEY_POOL_MAX) begin
                void'(key_pool.pop_front());
            end
        end else if (roll < 75 && key_pool.size() != 0) begin
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            queue_item(OP_TEST, key.hash_a, key.hash_b);
        end else begin
            queue_item(OP_TEST, key.hash_a, key.hash_b);
        end
    endtask

    initial begin
        shadow_num_bits   = NUM_BITS_RST;
        shadow_num_hashes = NUM_HASHES_RST;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // hold off until the store clear sweep is over
        repeat (2) @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // reset setting: hash extremes
        queue_item(OP_INSERT, HASH_ZERO, HASH_ZERO);
        queue_item(OP_TEST,   HASH_ZERO, HASH_ZERO);
        queue_item(OP_TEST,   HASH_ONES, HASH_ONES);
        queue_item(OP_INSERT, HASH_ONES, HASH_ONES);
        queue_item(OP_TEST,   HASH_ONES, HASH_ONES);
        queue_item(OP_TEST,   64'h1, 64'h8000_0000_0000_0000);
        settle_block();

        // zero bit count and too few hashes: every probe lands on bit zero
        set_reg(CFG_NUM_BITS, 32'd0);
        set_reg(CFG_NUM_HASHES, 32'd0);
        queue_item(OP_TEST,   rand_hash(), rand_hash());
        queue_item(OP_INSERT, rand_hash(), rand_hash());
        settle_block();

        // oversized bit count via masked data, too many hashes
        set_reg(CFG_NUM_BITS, 32'hFFFF_FFFF);
        set_reg(CFG_NUM_HASHES, 32'h0000_003F);
        queue_item(OP_TEST,   HASH_ZERO, HASH_ZERO);
        queue_item(OP_INSERT, HASH_ONES, HASH_ZERO);
        queue_item(OP_TEST,   HASH_ONES, HASH_ZERO);
        queue_item(OP_TEST,   64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        settle_block();

        // just past the store size, one hash raised to the minimum
        set_reg(CFG_NUM_BITS, 32'h0001_0001);
        set_reg(CFG_NUM_HASHES, 32'd1);
        queue_item(OP_TEST, HASH_ONES, HASH_ONES);
        settle_block();

        // unknown index is dropped; shrink the filter without clearing it
        set_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        set_reg(CFG_NUM_BITS, 32'd64);
        set_reg(CFG_NUM_HASHES, t_cfg_data'(HASHES_MAX));
        queue_item(OP_TEST,   HASH_ONES, HASH_ONES);
        queue_item(OP_INSERT, rand_hash(), rand_hash());
        queue_item(OP_TEST,   HASH_ZERO, HASH_ZERO);
        settle_block();

        // grow back: earlier keys must still be found
        set_reg(CFG_NUM_BITS, FILTER_BITS);
        set_reg(CFG_NUM_HASHES, t_cfg_data'(NUM_HASHES_RST));
        queue_item(OP_TEST, HASH_ONES, HASH_ONES);
        queue_item(OP_TEST, HASH_ZERO, HASH_ZERO);
        settle_block();

        // single-bit filter at the minimum probe count
        set_reg(CFG_NUM_BITS, 32'd1);
        set_reg(CFG_NUM_HASHES, t_cfg_data'(HASHES_MIN));
        queue_item(OP_TEST, rand_hash(), rand_hash());
        settle_block();

        // random phases, each under a fresh setting
        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            pick_setting();
            repeat ($urandom_range(20, 60)) begin
                random_item();
                random_count++;
            end
            settle_block();
        end

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/bfdh_pkg.sv
rtl/core/bfdh_ram.sv
rtl/core/bloom_filter_double_hash_core.sv
sim/tb_bloom_filter_double_hash_core.sv
